// ===== rtl/pcrcf_pkg.sv =====
// Types and constants shared by the region counting filter.
// No dependencies; compiled first.
`default_nettype none

package pcrcf_pkg;

   // Table sizes. NUM_ENTRIES must be a power of two (index is a bit slice).
   localparam int NUM_PROCS   = 16;
   localparam int NUM_ENTRIES = 1024;

   localparam int ADDR_W      = 48;
   localparam int CMD_W       = 2;
   localparam int PROC_ID_W   = 8;
   localparam int COUNT_W     = 16;
   localparam int HOLDER_W    = 5;
   localparam int HOLDER_CAP  = 16;
   localparam int REGION_SHIFT = 12;
   localparam int IDX_W       = $clog2(NUM_ENTRIES);
   localparam int CNT_W       = $clog2(NUM_PROCS + 1);
   localparam int SUM_W       = (CNT_W > HOLDER_W) ? CNT_W : HOLDER_W;

   localparam logic [ADDR_W-1:0]  MASK_RESET = ADDR_W'(4095);
   localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

   // APB side
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam logic CSR_REG_REGION_MASK = 1'b0;   // paddr[3]

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   // classified word handed from front to back
   typedef struct packed {
      cmd_type               cmd;
      logic                  proc_valid;
      logic [PROC_ID_W-1:0]  proc;
      logic [IDX_W-1:0]      index;
   } item_type;

   typedef logic [NUM_PROCS-1:0][COUNT_W-1:0] row_type;

endpackage

`default_nettype wire

// ===== rtl/pcrcf_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on pcrcf_pkg.
`default_nettype none

interface pcrcf_req_if;
   import pcrcf_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [ADDR_W-1:0]    address;
   logic [PROC_ID_W-1:0] proc;

   modport source (output valid, cmd, address, proc, input ready);
   modport sink   (input valid, cmd, address, proc, output ready);
endinterface

interface pcrcf_rsp_if;
   import pcrcf_pkg::*;
   logic                valid;
   logic                ready;
   logic                proc_valid;
   logic                may_contain;
   logic [HOLDER_W-1:0] holder_count;
   logic                not_shared;

   modport source (output valid, proc_valid, may_contain, holder_count, not_shared,
                   input ready);
   modport sink   (input valid, proc_valid, may_contain, holder_count, not_shared,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/pcrcf_front.sv =====
// Front end: CSR register, request accept and classification (index, proc check).
// Depends on pcrcf_pkg and pcrcf_req_if.
`default_nettype none

module pcrcf_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   pcrcf_req_if.sink                            req_ch,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [pcrcf_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [pcrcf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [pcrcf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready,
   input  wire logic                            q_full,
   input  wire logic                            clear_done,
   output logic                                 push,
   output pcrcf_pkg::item_type                  push_item
);
   import pcrcf_pkg::*;

   logic [ADDR_W-1:0] mask_ff, mask_in;
   logic [ADDR_W-1:0] region;
   logic              csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[3] == CSR_REG_REGION_MASK);

   always_comb begin
      mask_in = mask_ff;
      if (csr_wr) begin
         mask_in = pwdata[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[3] == CSR_REG_REGION_MASK) begin
         prdata = CSR_DATA_W'(mask_ff);
      end
   end

   // hold off requests during the post-reset clear pass and while the queue is full
   assign req_ch.ready = !q_full && clear_done;
   assign push         = req_ch.valid && req_ch.ready;

   assign region = req_ch.address & ~mask_ff;

   always_comb begin
      push_item.cmd        = cmd_type'(req_ch.cmd);
      push_item.proc       = req_ch.proc;
      push_item.proc_valid = (32'(req_ch.proc) < NUM_PROCS);
      push_item.index      = region[REGION_SHIFT +: IDX_W];
   end

endmodule

`default_nettype wire

// ===== rtl/pcrcf_queue.sv =====
// Short FIFO of classified words between front and back.
// Depends on pcrcf_pkg.
`default_nettype none

module pcrcf_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  pcrcf_pkg::item_type      push_item,
   input  wire logic                pop,
   output pcrcf_pkg::item_type      head,
   output logic                     full,
   output logic                     not_empty
);
   import pcrcf_pkg::*;

   item_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pcrcf_back.sv =====
// Back end: counter memory, clear pass, read-modify-write and query, response register.
// Depends on pcrcf_pkg and pcrcf_rsp_if.
`default_nettype none

module pcrcf_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  pcrcf_pkg::item_type  head,
   input  wire logic            not_empty,
   output logic                 pop,
   output logic                 clear_done,
   pcrcf_rsp_if.source          rsp_ch
);
   import pcrcf_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    clr_idx_ff, clr_idx_in;
   item_type            item_ff, item_in;
   row_type             rd_data_ff;
   row_type             counters_mem [NUM_ENTRIES];

   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   row_type             mem_wdata;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                may_ff, may_in;
   logic [HOLDER_W-1:0] holder_ff, holder_in;
   logic                alone_ff, alone_in;
   logic                pvalid_ff, pvalid_in;

   logic [NUM_PROCS-1:0] sel, nz, others;
   logic [SUM_W-1:0]     cnt;
   logic [COUNT_W-1:0]   cur, upd;
   logic                 out_free, is_query;

   assign clear_done = (state_ff != ST_CLEAR);
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign pop        = (state_ff == ST_IDLE) && not_empty && out_free;
   assign is_query   = (item_ff.cmd == CMD_QUERY);

   // lane decode and per-lane status of the row just read
   always_comb begin
      cnt = '0;
      cur = '0;
      for (int i = 0; i < NUM_PROCS; i++) begin
         sel[i]    = item_ff.proc_valid && (32'(item_ff.proc) == i);
         nz[i]     = (rd_data_ff[i] != '0);
         others[i] = nz[i] && !sel[i];
         cnt       = cnt + SUM_W'(others[i]);
         if (sel[i]) begin
            cur = cur | rd_data_ff[i];
         end
      end
   end

   always_comb begin
      case (item_ff.cmd)
         CMD_INSERT: upd = (cur == COUNT_MAX) ? cur : cur + 1'b1;
         CMD_REMOVE: upd = (cur == '0) ? cur : cur - 1'b1;
         default:    upd = '0;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = item_ff.index;
      mem_wdata = rd_data_ff;
      for (int i = 0; i < NUM_PROCS; i++) begin
         if (sel[i]) begin
            mem_wdata[i] = upd;
         end
      end
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_idx_ff;
         mem_wdata = '0;
      end else if (state_ff == ST_EXEC) begin
         mem_we = !is_query && item_ff.proc_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         counters_mem[mem_waddr] <= mem_wdata;
      end
      if (pop) begin
         rd_data_ff <= counters_mem[head.index];
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      item_in    = item_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == IDX_W'(NUM_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop) begin
               item_in  = head;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   // response word; output is free when EXEC is reached (checked at pop)
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      pvalid_in    = pvalid_ff;
      may_in       = may_ff;
      holder_in    = holder_ff;
      alone_in     = alone_ff;
      if (state_ff == ST_EXEC) begin
         rsp_valid_in = 1'b1;
         pvalid_in    = item_ff.proc_valid;
         may_in       = is_query && |(nz & sel);
         holder_in    = '0;
         if (is_query) begin
            holder_in = (cnt > SUM_W'(HOLDER_CAP)) ? HOLDER_W'(HOLDER_CAP)
                                                    : HOLDER_W'(cnt);
         end
         alone_in     = is_query && (cnt == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      pvalid_ff <= pvalid_in;
      may_ff    <= may_in;
      holder_ff <= holder_in;
      alone_ff  <= alone_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.proc_valid   = pvalid_ff;
   assign rsp_ch.may_contain  = may_ff;
   assign rsp_ch.holder_count = holder_ff;
   assign rsp_ch.not_shared   = alone_ff;

endmodule

`default_nettype wire

// ===== rtl/per_core_region_counting_filter_top.sv =====
// Top level of the per-core region counting filter.
// Depends on pcrcf_pkg, pcrcf_if, pcrcf_front, pcrcf_queue, pcrcf_back.
`default_nettype none

// Per-core region counting filter: one bank of 16-bit saturating counters per
// processor, indexed by (address & ~region_mask) >> 12 modulo NUM_ENTRIES.
// Insert/remove/clear update the requesting core's counter; query returns
// whether that core holds the region and how many other cores do. Each request
// word produces exactly one response word. After reset the back end walks the
// counter memory one row per cycle to zero it, with req_ch.ready held low;
// CSR writes are accepted throughout. In steady state the back end takes a word
// from the queue, reads the counter row of all cores from the single-ported
// counter memory, then updates or evaluates it and writes it back, and only
// then takes the next word; the result goes to the response register. A
// two-entry queue sits between the accept logic and the counter logic, and the
// response is registered, so requests are still taken while a response waits,
// until the queue is full. region_mask sits at byte address 0 of the 64-bit APB
// port; pready is always high.
module per_core_region_counting_filter_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   pcrcf_req_if.sink                            req_ch,
   pcrcf_rsp_if.source                          rsp_ch,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [pcrcf_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [pcrcf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [pcrcf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready
);
   import pcrcf_pkg::*;

   logic     push, pop, q_full, q_not_empty, clear_done;
   item_type push_item, head;

   pcrcf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .q_full     (q_full),
      .clear_done (clear_done),
      .push       (push),
      .push_item  (push_item)
   );

   pcrcf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   pcrcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .not_empty  (q_not_empty),
      .pop        (pop),
      .clear_done (clear_done),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire
